// ===== hdl/smatch_pkg.sv =====
// Shared types and constants for the stable matching engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package smatch_pkg;

  // Largest group size; the 4-bit index fields fix it.
  localparam int unsigned MaxPeople = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CntW      = 5;

  typedef enum logic [1:0] {
    OP_LOAD_MAN   = 2'd0,
    OP_LOAD_WOMAN = 2'd1,
    OP_START      = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_FETCH,
    ST_CMP,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write a preference table entry from the input word
    logic clear;    // reset the run state at the start of a run
    logic pick;     // choose the next free man and issue his proposal
    logic fetch;    // judge the proposal once the woman is known
    logic cmp;      // settle a contest between two men
    logic out_adv;  // step to the next result pair
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic man_avail;     // a queued or a not yet started man exists
    logic cand_done;     // the chosen man has tried his whole list
    logic woman_engaged; // proposal goes to an engaged, taking-part woman
    logic order_nonzero; // at least one woman got engaged
    logic out_last;      // current result pair is the final one
  } sts_t;

endpackage

// ===== hdl/smatch_ctrl.sv =====
// Controller state machine of the stable matching engine.
// Depends on smatch_pkg; drives the datapath through cmd_t and reads sts_t.
module smatch_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  smatch_pkg::op_t    in_op,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  smatch_pkg::sts_t   sts,
  output smatch_pkg::cmd_t   cmd
);

  smatch_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smatch_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smatch_pkg::ST_IDLE: begin
        if (in_tvalid && in_op == smatch_pkg::OP_START) state_nxt = smatch_pkg::ST_PICK;
      end
      smatch_pkg::ST_PICK: begin
        if (sts.man_avail) begin
          state_nxt = sts.cand_done ? smatch_pkg::ST_PICK : smatch_pkg::ST_FETCH;
        end else begin
          state_nxt = sts.order_nonzero ? smatch_pkg::ST_OUT : smatch_pkg::ST_IDLE;
        end
      end
      smatch_pkg::ST_FETCH: begin
        state_nxt = sts.woman_engaged ? smatch_pkg::ST_CMP : smatch_pkg::ST_PICK;
      end
      smatch_pkg::ST_CMP: state_nxt = smatch_pkg::ST_PICK;
      smatch_pkg::ST_OUT: begin
        if (out_tready && sts.out_last) state_nxt = smatch_pkg::ST_IDLE;
      end
      default: state_nxt = smatch_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      smatch_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid && (in_op == smatch_pkg::OP_LOAD_MAN ||
                                  in_op == smatch_pkg::OP_LOAD_WOMAN);
        cmd.clear = in_tvalid && in_op == smatch_pkg::OP_START;
      end
      smatch_pkg::ST_PICK:  cmd.pick  = sts.man_avail;
      smatch_pkg::ST_FETCH: cmd.fetch = 1'b1;
      smatch_pkg::ST_CMP:   cmd.cmp   = 1'b1;
      smatch_pkg::ST_OUT: begin
        out_tvalid  = 1'b1;
        cmd.out_adv = out_tready;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/smatch_dp.sv =====
// Datapath of the stable matching engine: preference memories, per-person
// state, the free-man queue and the result list. Depends on smatch_pkg.
module smatch_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [4:0]        cfg_data,
  input  smatch_pkg::op_t   in_op,
  input  logic [3:0]        in_person,
  input  logic [3:0]        in_position,
  input  logic [3:0]        in_choice,
  input  smatch_pkg::cmd_t  cmd,
  output smatch_pkg::sts_t  sts,
  output logic [3:0]        out_man,
  output logic [3:0]        out_woman
);

  localparam int unsigned N  = smatch_pkg::MaxPeople;
  localparam int unsigned IW = smatch_pkg::IdxW;
  localparam int unsigned CW = smatch_pkg::CntW;

  // Preference memories, one read port each plus a second on the rank table.
  logic [IW-1:0] man_prefs  [N*N];
  logic [IW-1:0] woman_rank [N*N];
  logic [IW-1:0] pref_rd_r, rank_a_r, rank_b_r;

  logic [CW-1:0] active_r;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] next_choice_r [N];
  logic [N-1:0]  engaged_r;
  logic [IW-1:0] partner_r [N];
  logic [IW-1:0] queue_r [N];
  logic [IW-1:0] head_r, tail_r;
  logic [CW-1:0] qcount_r;
  logic [CW-1:0] new_man_r;
  logic [IW-1:0] order_r [N];
  logic [CW-1:0] ocount_r;
  logic [CW-1:0] k_r;
  logic [IW-1:0] man_r, woman_r;

  logic [IW-1:0] cand;
  logic          qnz;
  logic [IW-1:0] fw;
  logic          fw_out;
  logic          push_en;
  logic [IW-1:0] push_man;

  // Active count, clamped to the supported range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= CW'(N);
    end else if (cfg_valid) begin
      active_r <= cfg_data;
    end
  end
  assign n_eff = (active_r == '0) ? CW'(1) : (active_r > CW'(N)) ? CW'(N) : active_r;

  // Candidate man: the queue comes first, then the next man in index order.
  assign qnz  = qcount_r != '0;
  assign cand = qnz ? queue_r[head_r] : new_man_r[IW-1:0];
  assign fw     = pref_rd_r;
  assign fw_out = {1'b0, fw} >= n_eff;

  assign sts.man_avail     = qnz || (new_man_r < n_eff);
  assign sts.cand_done     = next_choice_r[cand] >= n_eff;
  assign sts.woman_engaged = !fw_out && engaged_r[fw];
  assign sts.order_nonzero = ocount_r != '0;
  assign sts.out_last      = (k_r + CW'(1)) == ocount_r;

  // Loser of a proposal or a contest rejoins the queue.
  always_comb begin
    push_en  = 1'b0;
    push_man = man_r;
    if (cmd.fetch && fw_out) begin
      push_en = 1'b1;
    end else if (cmd.cmp) begin
      push_en  = 1'b1;
      push_man = (rank_a_r < rank_b_r) ? partner_r[woman_r] : man_r;
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load && in_op == smatch_pkg::OP_LOAD_MAN) begin
      man_prefs[{in_person, in_position}] <= in_choice;
    end
    if (cmd.load && in_op == smatch_pkg::OP_LOAD_WOMAN) begin
      woman_rank[{in_person, in_choice}] <= in_position;
    end
    if (cmd.pick) begin
      pref_rd_r <= man_prefs[{cand, next_choice_r[cand][IW-1:0]}];
    end
    if (cmd.fetch) begin
      rank_a_r <= woman_rank[{fw, man_r}];
      rank_b_r <= woman_rank[{fw, partner_r[fw]}];
    end
  end

  // Run state: queue, choice counters, engagements and the result list.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      engaged_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      qcount_r  <= '0;
      new_man_r <= '0;
      ocount_r  <= '0;
      k_r       <= '0;
      for (int i = 0; i < N; i++) next_choice_r[i] <= '0;
    end else begin
      if (cmd.pick) begin
        man_r <= cand;
        if (qnz) begin
          head_r   <= head_r + IW'(1);
          qcount_r <= qcount_r - CW'(1);
        end else begin
          new_man_r <= new_man_r + CW'(1);
        end
        if (!sts.cand_done) next_choice_r[cand] <= next_choice_r[cand] + CW'(1);
      end
      if (cmd.fetch) begin
        woman_r <= fw;
        if (!fw_out && !engaged_r[fw]) begin
          engaged_r[fw] <= 1'b1;
          partner_r[fw] <= man_r;
          if (ocount_r < CW'(N)) begin
            order_r[ocount_r[IW-1:0]] <= fw;
            ocount_r <= ocount_r + CW'(1);
          end
        end
      end
      if (cmd.cmp && rank_a_r < rank_b_r) partner_r[woman_r] <= man_r;
      if (push_en && qcount_r < CW'(N)) begin
        queue_r[tail_r] <= push_man;
        tail_r   <= tail_r + IW'(1);
        qcount_r <= qcount_r + CW'(1);
      end
      if (cmd.out_adv) k_r <= k_r + CW'(1);
    end
  end

  // Current result pair.
  assign out_woman = order_r[k_r[IW-1:0]];
  assign out_man   = partner_r[out_woman];

endmodule

// ===== hdl/stable_matching_engine_top.sv =====
// Top level of the stable matching engine.
// Depends on smatch_pkg, smatch_ctrl and smatch_dp.
// Load words write the preference tables. A start word runs men-proposing
// Gale-Shapley matching: each proposal goes through the preference memory
// read (PICK, FETCH), adding a compare of two ranks (CMP) when the woman is
// engaged, and each man with an exhausted list is skipped in PICK. The pairs
// then leave one per cycle while out_tready is high, in order of each woman's
// first engagement, tlast on the final pair. No input word is taken while a
// run or its results are in progress.
module stable_matching_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,    // active_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // operation[1:0], person[5:2], position[9:6], choice[13:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // man_index[3:0], woman_index[7:4]
  output logic        out_tlast
);

  smatch_pkg::cmd_t cmd;
  smatch_pkg::sts_t sts;
  smatch_pkg::op_t  op;
  logic [3:0]       man, woman;

  assign cfg_ready = 1'b1;
  assign op        = smatch_pkg::op_t'(in_tdata[1:0]);

  smatch_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_op(op),
    .out_tvalid, .out_tready, .sts, .cmd
  );

  smatch_dp u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_data, .in_op(op),
    .in_person(in_tdata[5:2]), .in_position(in_tdata[9:6]),
    .in_choice(in_tdata[13:10]), .cmd, .sts,
    .out_man(man), .out_woman(woman)
  );

  assign out_tdata = {woman, man};
  assign out_tlast = sts.out_last;

endmodule

// ===== hdl/smatch_checker.sv =====
// Port-level checks for the stable matching engine, bound to its top level.
// Depends only on the top level's ports.
module smatch_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // No input word is taken while results are being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input ready during result delivery");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // The run's final word ends the result stream.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("results continue after last");

endmodule

bind stable_matching_engine_top smatch_checker u_smatch_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for stable_matching_engine_top.
// Depends on smatch_pkg and the RTL; it loads preference tables, runs
// matchings and checks every pair word against typed pairs or its own matching predictor.
module tb_top;

  localparam int unsigned MaxPeople = smatch_pkg::MaxPeople;
  localparam int unsigned IdxW = smatch_pkg::IdxW;
  localparam int unsigned CntW = smatch_pkg::CntW;
  localparam int unsigned PeriodT = 12;
  localparam int unsigned MaxRunCycles = 3 * MaxPeople * MaxPeople + 40;

  typedef struct packed {
    logic [IdxW-1:0] man;
    logic [IdxW-1:0] woman;
    logic            last;
  } pair_t;

  // One row of the directed part: a register write or an input word.
  typedef struct {
    bit               is_cfg;
    logic [CntW-1:0]  cfg_val;
    smatch_pkg::op_t  op;
    logic [IdxW-1:0]  person;
    logic [IdxW-1:0]  position;
    logic [IdxW-1:0]  choice;
    int               n_typed;   // pairs typed in below, or -1 to use the predictor
    pair_t            typed [2];
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CntW-1:0]   cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;    // operation[1:0], person[5:2], position[9:6], choice[13:10]
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;   // man_index[3:0], woman_index[7:4]
  logic              out_tlast;

  // Predictor state: tables, which entries were loaded, and the group size.
  logic [IdxW-1:0] man_list [MaxPeople][MaxPeople];
  logic [IdxW-1:0] woman_rank [MaxPeople][MaxPeople];
  bit              man_list_set [MaxPeople][MaxPeople];
  bit              woman_rank_set [MaxPeople][MaxPeople];
  logic [CntW-1:0] group_size;

  pair_t pending_pairs [$];

  int errors;
  int words_sent;
  int starts_sent;
  int pairs_seen;
  int idle_pct;
  int stall_pct;
  int hold_reqs;
  int hold_done;
  int hold_left;

  stable_matching_engine_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(PeriodT / 2) clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(PeriodT * 3_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Effective group size: zero acts as one, anything above the maximum as the maximum.
  function automatic int unsigned eff_size();
    if (group_size == 0) return 1;
    if (group_size > MaxPeople) return MaxPeople;
    return 32'(group_size);
  endfunction

  // Men-proposing matching on the predictor tables. With emit set it queues
  // the pairs in order of first engagement; otherwise it stops at the first
  // table entry the run would read before it was loaded and reports it.
  function automatic bit run_model(input bit emit, output bit gap_man,
                                   output int unsigned gap_a, output int unsigned gap_b);
    int unsigned n;
    int unsigned tried [MaxPeople];
    bit          taken [MaxPeople];
    int unsigned partner [MaxPeople];
    int unsigned rejected [$];
    int unsigned first_engaged [$];
    int unsigned new_man;
    int unsigned man;
    int unsigned woman;
    int unsigned rival;
    pair_t       p;
    gap_man = 0;
    gap_a = 0;
    gap_b = 0;
    n = eff_size();
    new_man = 0;
    foreach (tried[i]) begin
      tried[i] = 0;
      taken[i] = 0;
      partner[i] = 0;
    end
    forever begin
      if (rejected.size() > 0) man = rejected.pop_front();
      else if (new_man < n) begin
        man = new_man;
        new_man++;
      end else break;
      if (tried[man] >= n) continue;
      if (!emit && !man_list_set[man][tried[man]]) begin
        gap_man = 1;
        gap_a = man;
        gap_b = tried[man];
        return 1;
      end
      woman = 32'(man_list[man][tried[man]]);
      tried[man]++;
      if (woman >= n) begin
        rejected.push_back(man);
      end else if (!taken[woman]) begin
        taken[woman] = 1;
        partner[woman] = man;
        first_engaged.push_back(woman);
      end else begin
        rival = partner[woman];
        if (!emit && !woman_rank_set[woman][man]) begin
          gap_a = woman;
          gap_b = man;
          return 1;
        end
        if (!emit && !woman_rank_set[woman][rival]) begin
          gap_a = woman;
          gap_b = rival;
          return 1;
        end
        // Ties go to the current partner.
        if (woman_rank[woman][man] < woman_rank[woman][rival]) begin
          partner[woman] = man;
          rejected.push_back(rival);
        end else begin
          rejected.push_back(man);
        end
      end
    end
    if (emit) begin
      foreach (first_engaged[k]) begin
        p.man = IdxW'(partner[first_engaged[k]]);
        p.woman = IdxW'(first_engaged[k]);
        p.last = (k == first_engaged.size() - 1);
        pending_pairs.push_back(p);
      end
    end
    return 0;
  endfunction

  // Queues the pairs that a start word produces.
  function automatic void predict_matching();
    bit          gap_man;
    int unsigned gap_a;
    int unsigned gap_b;
    void'(run_model(1'b1, gap_man, gap_a, gap_b));
  endfunction

  // Updates the tables for one accepted input word; returns true for a start.
  function automatic bit apply_word(smatch_pkg::op_t op, logic [IdxW-1:0] who,
                                    logic [IdxW-1:0] pos, logic [IdxW-1:0] pick);
    case (op)
      smatch_pkg::OP_LOAD_MAN: begin
        man_list[who][pos] = pick;
        man_list_set[who][pos] = 1;
      end
      smatch_pkg::OP_LOAD_WOMAN: begin
        woman_rank[who][pick] = pos;
        woman_rank_set[who][pick] = 1;
      end
      smatch_pkg::OP_START: return 1;
      default: ;
    endcase
    return 0;
  endfunction

  // Offers one word, with random gaps in front, and waits for it to be taken.
  task automatic send_word(smatch_pkg::op_t op, logic [IdxW-1:0] who,
                           logic [IdxW-1:0] pos, logic [IdxW-1:0] pick);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, pick, pos, who, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Sends a word and predicts what it causes.
  task automatic issue(smatch_pkg::op_t op, logic [IdxW-1:0] who,
                       logic [IdxW-1:0] pos, logic [IdxW-1:0] pick);
    send_word(op, who, pos, pick);
    if (apply_word(op, who, pos, pick)) begin
      starts_sent++;
      predict_matching();
    end
  endtask

  // Lets every result drain, then waits out a run that may give no pair.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_pairs.size() > 0) @(posedge clk);
    repeat (MaxRunCycles) @(posedge clk);
  endtask

  task automatic write_size(logic [CntW-1:0] value);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    group_size = value;
  endtask

  // Loads, one at a time, each table entry that the next run would read while still unset.
  task automatic fill_missing();
    bit          gap_man;
    int unsigned ga;
    int unsigned gb;
    int unsigned n;
    n = eff_size();
    while (run_model(1'b0, gap_man, ga, gb)) begin
      if (gap_man)
        issue(smatch_pkg::OP_LOAD_MAN, IdxW'(ga), IdxW'(gb),
              ($urandom_range(7) == 0) ? IdxW'($urandom_range(15))
                                       : IdxW'($urandom_range(n - 1)));
      else
        issue(smatch_pkg::OP_LOAD_WOMAN, IdxW'(ga), IdxW'($urandom_range(15)), IdxW'(gb));
    end
  endtask

  // Receiver: random stalls, plus long hold-offs asked for by the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= hold_done + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Checks each pair word against the oldest expected pair.
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair word man=%0d woman=%0d last=%0b",
               out_tdata[3:0], out_tdata[7:4], out_tlast);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_tdata[3:0] !== want.man) begin
          $error("man_index expected %0d got %0d", want.man, out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[7:4] !== want.woman) begin
          $error("woman_index expected %0d got %0d", want.woman, out_tdata[7:4]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last expected %0b got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t        rows [$];
    row_t        r;
    logic [CntW-1:0] sizes [8];
    int          phase_words;
    int          guard;
    bit          is_start;

    errors = 0;
    words_sent = 0;
    starts_sent = 0;
    pairs_seen = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    group_size = CntW'(MaxPeople);
    foreach (man_list[a, b]) begin
      man_list[a][b] = '0;
      woman_rank[a][b] = '0;
      man_list_set[a][b] = 0;
      woman_rank_set[a][b] = 0;
    end
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: one pair, a woman not taking part, an ignored word,
    // size zero, a contest the newcomer wins, and a tie the partner keeps.
    r = '{default: '0, op: smatch_pkg::OP_LOAD_MAN, n_typed: -1};
    r.is_cfg = 1; r.cfg_val = 1; rows.push_back(r);
    r.is_cfg = 0; r.op = smatch_pkg::OP_LOAD_MAN; rows.push_back(r);
    r.op = smatch_pkg::OP_START; r.n_typed = 1; r.typed[0] = '{0, 0, 1}; rows.push_back(r);
    r.n_typed = -1; r.op = smatch_pkg::OP_LOAD_MAN; r.choice = 15; rows.push_back(r);
    r.op = smatch_pkg::OP_START; r.n_typed = 0; rows.push_back(r);
    r.n_typed = -1; r.op = smatch_pkg::OP_NONE; r.person = 15; r.position = 15;
    rows.push_back(r);
    r.op = smatch_pkg::OP_LOAD_WOMAN; rows.push_back(r);
    r.op = smatch_pkg::OP_LOAD_MAN; r.person = 15; r.position = 15; r.choice = 15;
    rows.push_back(r);
    r.is_cfg = 1; r.cfg_val = 0; rows.push_back(r);
    r.is_cfg = 0; r.op = smatch_pkg::OP_LOAD_MAN; r.person = 0; r.position = 0;
    r.choice = 0; rows.push_back(r);
    r.op = smatch_pkg::OP_START; r.n_typed = 1; r.typed[0] = '{0, 0, 1}; rows.push_back(r);
    r.n_typed = -1; r.is_cfg = 1; r.cfg_val = 2; rows.push_back(r);
    r.is_cfg = 0; r.op = smatch_pkg::OP_LOAD_MAN;
    r.person = 0; r.position = 0; r.choice = 1; rows.push_back(r);
    r.person = 0; r.position = 1; r.choice = 0; rows.push_back(r);
    r.person = 1; r.position = 0; r.choice = 1; rows.push_back(r);
    r.person = 1; r.position = 1; r.choice = 0; rows.push_back(r);
    r.op = smatch_pkg::OP_LOAD_WOMAN;
    r.person = 1; r.position = 1; r.choice = 0; rows.push_back(r);
    r.person = 1; r.position = 0; r.choice = 1; rows.push_back(r);
    r.person = 0; r.position = 0; r.choice = 0; rows.push_back(r);
    r.person = 0; r.position = 1; r.choice = 1; rows.push_back(r);
    r.op = smatch_pkg::OP_START; r.n_typed = 2; r.typed[0] = '{1, 1, 0};
    r.typed[1] = '{0, 0, 1}; rows.push_back(r);
    r.n_typed = -1; r.op = smatch_pkg::OP_LOAD_WOMAN; r.person = 1; r.position = 1;
    r.choice = 1; rows.push_back(r);
    r.op = smatch_pkg::OP_START; r.n_typed = 2; r.typed[0] = '{0, 1, 0};
    r.typed[1] = '{1, 0, 1}; rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_size(rows[i].cfg_val);
      end else begin
        send_word(rows[i].op, rows[i].person, rows[i].position, rows[i].choice);
        is_start = apply_word(rows[i].op, rows[i].person, rows[i].position, rows[i].choice);
        if (is_start) begin
          starts_sent++;
          if (rows[i].n_typed < 0) predict_matching();
          else for (int k = 0; k < rows[i].n_typed; k++)
            pending_pairs.push_back(rows[i].typed[k]);
        end
      end
    end

    // Random phases: each sets a size and an idling pattern, then runs
    // well-formed load-and-start sequences with some noise mixed in.
    sizes = '{3, 5, 2, 7, 4, 31, 6, 16};
    for (int ph = 0; ph < 8; ph++) begin
      write_size(sizes[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      phase_words = words_sent;
      while (words_sent - phase_words < 50) begin
        repeat ($urandom_range(12)) begin
          case ($urandom_range(9))
            0: issue(smatch_pkg::OP_NONE, IdxW'($urandom_range(15)),
                     IdxW'($urandom_range(15)), IdxW'($urandom_range(15)));
            1: issue(smatch_pkg::OP_LOAD_MAN, IdxW'($urandom_range(15)),
                     IdxW'($urandom_range(15)), IdxW'($urandom_range(15)));
            2: issue(smatch_pkg::OP_LOAD_WOMAN, IdxW'($urandom_range(15)),
                     IdxW'($urandom_range(15)), IdxW'($urandom_range(15)));
            3, 4, 5: issue(smatch_pkg::OP_LOAD_WOMAN, IdxW'($urandom_range(eff_size() - 1)),
                           IdxW'($urandom_range(15)),
                           IdxW'($urandom_range(eff_size() - 1)));
            default: issue(smatch_pkg::OP_LOAD_MAN, IdxW'($urandom_range(eff_size() - 1)),
                           IdxW'($urandom_range(eff_size() - 1)),
                           IdxW'($urandom_range(eff_size() - 1)));
          endcase
        end
        fill_missing();
        issue(smatch_pkg::OP_START, IdxW'($urandom_range(15)), IdxW'($urandom_range(15)),
              IdxW'($urandom_range(15)));
        // Long receiver hold-off while the sender keeps offering words.
        if (ph == 2 && words_sent - phase_words < 30) hold_reqs++;
        // Sender pause until every pair has arrived.
        if (ph == 1) begin
          in_tvalid <= 1'b0;
          while (pending_pairs.size() > 0) @(posedge clk);
        end
      end
    end

    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_pairs.size() > 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (MaxRunCycles) @(posedge clk);
    $display("Ran %0d input words with %0d matching runs over sizes 1 to 16;",
             words_sent, starts_sent);
    $display("checked %0d pair words under varied idling and back-pressure.", pairs_seen);
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending_pairs.size() > 0)
        $error("%0d expected pairs never arrived", pending_pairs.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
